// ===== hdl/sba_pkg.sv =====
// spectral band average: shared types, constants and cordic angle table
// no dependencies

package sba_pkg;

   localparam int MAX_BINS = 4096;
   localparam int CNT_W = 13;
   localparam int SUM_W = 45;
   localparam int AVG_W = 33;
   localparam int FREQ_W = 24;
   localparam int CORDIC_STEPS = 14;
   localparam int STEP_W = 4;
   localparam int DIV_STEPS = 45;
   localparam int DIV_W = 6;
   localparam logic signed [17:0] PI_Q13 = 18'sd25736;
   localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;

   localparam logic [1:0] MODE_MAG = 2'd0;
   localparam logic [1:0] MODE_POWER = 2'd1;
   localparam logic [1:0] MODE_PHASE = 2'd2;

   localparam logic [1:0] REG_LOW = 2'd0;
   localparam logic [1:0] REG_HIGH = 2'd1;
   localparam logic [1:0] REG_MODE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_ACCUM,
      ST_DIVIDE,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic load;
      logic cordic_step;
      logic accum;
      logic div_start;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic is_phase;
      logic cordic_done;
      logic is_last;
      logic div_done;
   } status_type;

   function automatic logic signed [17:0] atan_q13(input logic [STEP_W-1:0] i);
      case (i)
         4'd0: atan_q13 = 18'sd6434;
         4'd1: atan_q13 = 18'sd3798;
         4'd2: atan_q13 = 18'sd2007;
         4'd3: atan_q13 = 18'sd1019;
         4'd4: atan_q13 = 18'sd511;
         4'd5: atan_q13 = 18'sd256;
         4'd6: atan_q13 = 18'sd128;
         4'd7: atan_q13 = 18'sd64;
         4'd8: atan_q13 = 18'sd32;
         4'd9: atan_q13 = 18'sd16;
         4'd10: atan_q13 = 18'sd8;
         4'd11: atan_q13 = 18'sd4;
         4'd12: atan_q13 = 18'sd2;
         4'd13: atan_q13 = 18'sd1;
         default: atan_q13 = 18'sd0;
      endcase
   endfunction

endpackage

// ===== hdl/sba_ctrl.sv =====
// spectral band average: controller state machine
// depends on sba_pkg

module sba_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_fire,
   input  logic rsp_fire,
   input  sba_pkg::status_type status,
   output sba_pkg::cmd_type cmd,
   output logic req_tready,
   output logic rsp_tvalid
);

   sba_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sba_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sba_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = sba_pkg::ST_CORDIC;
            end
         end
         sba_pkg::ST_CORDIC: begin
            if (!status.is_phase || status.cordic_done) begin
               state_in = sba_pkg::ST_ACCUM;
            end
         end
         sba_pkg::ST_ACCUM: begin
            state_in = status.is_last ? sba_pkg::ST_DIVIDE : sba_pkg::ST_IDLE;
         end
         sba_pkg::ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = sba_pkg::ST_OUTPUT;
            end
         end
         sba_pkg::ST_OUTPUT: begin
            if (rsp_fire) begin
               state_in = sba_pkg::ST_IDLE;
            end
         end
         default: state_in = sba_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         sba_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load = req_fire;
         end
         sba_pkg::ST_CORDIC: cmd.cordic_step = status.is_phase && !status.cordic_done;
         sba_pkg::ST_ACCUM: begin
            cmd.accum = 1'b1;
            cmd.div_start = status.is_last;
         end
         sba_pkg::ST_DIVIDE: begin
            cmd.div_step = !status.div_done;
            cmd.out_load = status.div_done;
         end
         sba_pkg::ST_OUTPUT: rsp_tvalid = 1'b1;
         default: ;
      endcase
   end

endmodule

// ===== hdl/sba_datapath.sv =====
// spectral band average: band test, cordic, accumulator and restoring divider
// depends on sba_pkg

module sba_datapath (
   input  logic clock,
   input  logic reset,
   input  sba_pkg::cmd_type cmd,
   output sba_pkg::status_type status,
   input  logic [23:0] band_low_freq,
   input  logic [23:0] band_high_freq,
   input  logic [1:0] average_mode,
   input  logic [23:0] bin_freq,
   input  logic [15:0] bin_value,
   input  logic signed [15:0] bin_real,
   input  logic signed [15:0] bin_imag,
   input  logic last_bin,
   output logic signed [32:0] band_average,
   output logic [12:0] bins_used
);

   logic [1:0] mode_ff;
   logic use_ff, last_ff;
   logic [15:0] value_ff;
   logic signed [15:0] re_ff, im_ff;
   logic signed [19:0] x_ff, y_ff;
   logic signed [17:0] z_ff;
   logic [sba_pkg::STEP_W-1:0] step_ff;
   logic signed [sba_pkg::SUM_W-1:0] sum_ff;
   logic [sba_pkg::CNT_W-1:0] count_ff;
   logic [sba_pkg::SUM_W-1:0] quo_ff;
   logic [sba_pkg::CNT_W:0] rem_ff;
   logic neg_ff;
   logic [sba_pkg::DIV_W-1:0] div_cnt_ff;
   logic signed [32:0] avg_ff;
   logic [12:0] used_ff;

   logic signed [19:0] x_in, y_in, xs, ys;
   logic signed [17:0] z_in, z_clamp, term_phase;
   logic signed [31:0] power;
   logic signed [sba_pkg::SUM_W-1:0] term, new_sum;
   logic [sba_pkg::CNT_W-1:0] new_count;
   logic [sba_pkg::CNT_W:0] rem_sh, rem_in;
   logic bit_in;
   logic [sba_pkg::SUM_W-1:0] mag_sum, q_neg;
   logic in_band;

   assign in_band = (band_low_freq <= bin_freq) && (bin_freq <= band_high_freq)
      && (count_ff < 13'(sba_pkg::MAX_BINS));

   assign xs = x_ff >>> step_ff;
   assign ys = y_ff >>> step_ff;

   always_comb begin
      if (y_ff > 0) begin
         x_in = x_ff + ys;
         y_in = y_ff - xs;
         z_in = z_ff + sba_pkg::atan_q13(step_ff);
      end else begin
         x_in = x_ff - ys;
         y_in = y_ff + xs;
         z_in = z_ff - sba_pkg::atan_q13(step_ff);
      end
   end

   always_comb begin
      z_clamp = z_ff;
      if (z_ff > sba_pkg::PI_Q13) z_clamp = sba_pkg::PI_Q13;
      if (z_ff < -sba_pkg::PI_Q13) z_clamp = -sba_pkg::PI_Q13;
      if (im_ff == 16'sd0) begin
         term_phase = (re_ff < 0) ? sba_pkg::PI_Q13 : 18'sd0;
      end else if (re_ff == 16'sd0) begin
         term_phase = (im_ff > 0) ? sba_pkg::HALF_PI_Q13 : -sba_pkg::HALF_PI_Q13;
      end else begin
         term_phase = z_clamp;
      end
   end

   assign power = re_ff * re_ff + im_ff * im_ff;

   always_comb begin
      case (mode_ff)
         sba_pkg::MODE_POWER: term = 45'(power) & 45'hFFFFFFFF;
         sba_pkg::MODE_PHASE: term = 45'(term_phase);
         default: term = 45'({1'b0, value_ff});
      endcase
   end

   assign new_sum = use_ff ? sum_ff + term : sum_ff;
   assign new_count = use_ff ? count_ff + 13'd1 : count_ff;
   assign mag_sum = new_sum[sba_pkg::SUM_W-1] ? 45'(-new_sum) : 45'(new_sum);

   assign rem_sh = {rem_ff[sba_pkg::CNT_W-1:0], quo_ff[sba_pkg::SUM_W-1]};
   assign bit_in = rem_sh >= {1'b0, count_ff};
   assign rem_in = bit_in ? rem_sh - {1'b0, count_ff} : rem_sh;
   assign q_neg = neg_ff ? 45'(-quo_ff) : quo_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= average_mode;
         use_ff <= in_band;
         last_ff <= last_bin;
         value_ff <= bin_value;
         re_ff <= bin_real;
         im_ff <= bin_imag;
         step_ff <= '0;
         if (bin_real < 0) begin
            x_ff <= -20'(bin_real);
            y_ff <= -20'(bin_imag);
            z_ff <= (bin_imag >= 0) ? sba_pkg::PI_Q13 : -sba_pkg::PI_Q13;
         end else begin
            x_ff <= 20'(bin_real);
            y_ff <= 20'(bin_imag);
            z_ff <= '0;
         end
      end else if (cmd.cordic_step) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
         step_ff <= step_ff + 4'd1;
      end
      if (cmd.div_start) begin
         quo_ff <= mag_sum;
         rem_ff <= '0;
         neg_ff <= new_sum[sba_pkg::SUM_W-1];
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[sba_pkg::SUM_W-2:0], bit_in};
         rem_ff <= rem_in;
         div_cnt_ff <= div_cnt_ff + 6'd1;
      end
      if (cmd.out_load) begin
         avg_ff <= (count_ff == '0) ? 33'sd0 : 33'(q_neg);
         used_ff <= count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         count_ff <= '0;
      end else if (cmd.out_load) begin
         sum_ff <= '0;
         count_ff <= '0;
      end else if (cmd.accum) begin
         sum_ff <= new_sum;
         count_ff <= new_count;
      end
   end

   assign status.is_phase = (mode_ff == sba_pkg::MODE_PHASE) && use_ff;
   assign status.cordic_done = step_ff == 4'(sba_pkg::CORDIC_STEPS);
   assign status.is_last = last_ff;
   assign status.div_done = div_cnt_ff == 6'(sba_pkg::DIV_STEPS);
   assign band_average = avg_ff;
   assign bins_used = used_ff;

endmodule

// ===== hdl/spectral_band_average_unit.sv =====
// spectral band average: top level with register file, controller and datapath
// depends on sba_pkg, sba_ctrl, sba_datapath

// One bin is taken per transaction; in phase mode a bin in band also runs the cordic (14
// iterations). After the last bin, the bit-serial divider runs its 45 steps and the result
// is loaded before the result transaction is offered; no new bin is taken until that
// result is taken.

module spectral_band_average_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [71:0] req_tdata,  // bin_freq, bin_value, bin_real, bin_imag
   input  logic req_tlast,         // last_bin
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [47:0] rsp_tdata,  // band_average, bins_used, zero fill
   input  logic csr_we,
   input  logic [1:0] csr_index,
   input  logic [23:0] csr_wdata
);

   logic [23:0] low_ff, high_ff;
   logic [1:0] mode_ff;
   sba_pkg::cmd_type cmd;
   sba_pkg::status_type status;
   logic signed [32:0] band_average;
   logic [12:0] bins_used;
   logic req_fire, rsp_fire;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff <= '0;
         high_ff <= '0;
         mode_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            sba_pkg::REG_LOW: low_ff <= csr_wdata;
            sba_pkg::REG_HIGH: high_ff <= csr_wdata;
            sba_pkg::REG_MODE: mode_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   sba_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_fire(req_fire),
      .rsp_fire(rsp_fire),
      .status(status),
      .cmd(cmd),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid)
   );

   sba_datapath u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .band_low_freq(low_ff),
      .band_high_freq(high_ff),
      .average_mode(mode_ff),
      .bin_freq(req_tdata[23:0]),
      .bin_value(req_tdata[39:24]),
      .bin_real(req_tdata[55:40]),
      .bin_imag(req_tdata[71:56]),
      .last_bin(req_tlast),
      .band_average(band_average),
      .bins_used(bins_used)
   );

   assign rsp_tdata = {2'b00, bins_used, band_average};

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("input and result offered together");
   a_result_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |=> !rsp_tvalid) else $error("result repeated");
   a_cordic_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.cordic_step |-> !status.cordic_done) else $error("cordic overran");

endmodule

// ===== test/spectral_band_average_unit_tb.sv =====
// spectral band average: self-checking testbench with a directed table and random frames
// depends on sba_pkg and spectral_band_average_unit

module spectral_band_average_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [32:0] avg;
      logic [12:0] used;
   } band_result_type;

   typedef struct {
      bit cfg;
      logic [23:0] low, high;
      logic [1:0] mode;
      logic [23:0] freq;
      logic [15:0] value;
      logic signed [15:0] re, im;
      bit last;
      bit typed;
      logic [32:0] avg;
      logic [12:0] used;
   } bin_row_type;

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tlast = 0, rsp_tready = 0, csr_we = 0;
   logic [71:0] req_tdata = '0;
   logic [1:0] csr_index = sba_pkg::REG_LOW;
   logic [23:0] csr_wdata = '0;
   logic req_tready, rsp_tvalid;
   logic [47:0] rsp_tdata;

   band_result_type pending_q[$];
   int mismatches = 0;
   int cycles = 0;
   bit calm = 0;
   bit hold_now = 0;
   bit hold_done = 0;
   int hold_left = 0;

   logic [23:0] p_low = 0, p_high = 0;
   logic [1:0] p_mode = sba_pkg::MODE_MAG;
   longint p_sum = 0;
   int p_count = 0;

   spectral_band_average_unit u_dut (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 1000000) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_now && !hold_done && hold_left == 0) begin
         hold_left <= 400;
         hold_done <= 1;
         rsp_tready <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 27);
      end
   end

   always @(posedge clock) begin
      band_result_type want;
      logic [32:0] got_avg;
      logic [12:0] got_used;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_avg = rsp_tdata[32:0];
         got_used = rsp_tdata[45:33];
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transaction avg=%0d used=%0d",
                        $signed(got_avg), got_used);
         end else begin
            want = pending_q.pop_front();
            if (want.avg !== got_avg || want.used !== got_used) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected avg=%0d used=%0d, got avg=%0d used=%0d",
                           $signed(want.avg), want.used, $signed(got_avg), got_used);
            end
         end
      end
   end

   function automatic longint cordic_phase(longint re, longint im);
      longint x, y, z, nx, ny;
      longint angles[14] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1};
      if (im == 0) return (re < 0) ? 25736 : 0;
      if (re == 0) return (im > 0) ? 12868 : -12868;
      if (re < 0) begin
         x = -re; y = -im; z = (im >= 0) ? 25736 : -25736;
      end else begin
         x = re; y = im; z = 0;
      end
      for (int i = 0; i < 14; i++) begin
         if (y > 0) begin
            nx = x + (y >>> i); ny = y - (x >>> i); z += angles[i];
         end else begin
            nx = x - (y >>> i); ny = y + (x >>> i); z -= angles[i];
         end
         x = nx; y = ny;
      end
      if (z > 25736) z = 25736;
      if (z < -25736) z = -25736;
      return z;
   endfunction

   // returns 1 with the band average when the bin closes a spectrum
   function automatic bit accumulate_bin(logic [71:0] data, bit last,
                                         output band_result_type res);
      longint re, im, term, avg;
      logic [23:0] freq;
      freq = data[23:0];
      re = longint'($signed(data[55:40]));
      im = longint'($signed(data[71:56]));
      if (p_low <= freq && freq <= p_high && p_count < sba_pkg::MAX_BINS) begin
         if (p_mode == sba_pkg::MODE_POWER) term = re * re + im * im;
         else if (p_mode == sba_pkg::MODE_PHASE) term = cordic_phase(re, im);
         else term = longint'(data[39:24]);
         p_sum += term;
         p_count++;
      end
      if (!last) return 0;
      avg = (p_count == 0) ? 0 : p_sum / p_count;
      res.avg = avg[32:0];
      res.used = p_count[12:0];
      p_sum = 0;
      p_count = 0;
      return 1;
   endfunction

   task automatic write_reg(logic [1:0] idx, logic [23:0] val);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      if (idx == sba_pkg::REG_LOW) p_low = val;
      else if (idx == sba_pkg::REG_HIGH) p_high = val;
      else if (idx == sba_pkg::REG_MODE) p_mode = val[1:0];
      @(posedge clock);
   endtask

   task automatic settle_and_configure(logic [23:0] low, logic [23:0] high, logic [1:0] mode);
      req_tvalid <= 0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      write_reg(sba_pkg::REG_LOW, low);
      write_reg(sba_pkg::REG_HIGH, high);
      write_reg(sba_pkg::REG_MODE, mode);
   endtask

   task automatic send_bin(logic [23:0] freq, logic [15:0] value, logic signed [15:0] re,
                           logic signed [15:0] im, bit last, bit typed,
                           band_result_type typed_res);
      logic [71:0] data;
      band_result_type res;
      int gap;
      if (!calm && $urandom_range(99) < 27) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      data = {im, re, value, freq};
      req_tvalid <= 1; req_tdata <= data; req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      if (accumulate_bin(data, last, res))
         pending_q.push_back(typed ? typed_res : res);
   endtask

   bin_row_type rows[$];
   band_result_type r;

   function automatic bin_row_type mk(logic [23:0] f, logic [15:0] v, logic signed [15:0] re,
                                     logic signed [15:0] im, bit last, bit typed,
                                     logic [32:0] avg, logic [12:0] used);
      bin_row_type t;
      t = '{default: '0};
      t.freq = f; t.value = v; t.re = re; t.im = im; t.last = last;
      t.typed = typed; t.avg = avg; t.used = used;
      return t;
   endfunction

   function automatic bin_row_type mkcfg(bin_row_type t, logic [23:0] lo, logic [23:0] hi,
                                        logic [1:0] mode);
      t.cfg = 1; t.low = lo; t.high = hi; t.mode = mode;
      return t;
   endfunction

   initial begin
      logic [23:0] lo, hi;
      int nframes, len;
      rows.push_back(mk(24'd0, 16'hFFFF, 16'sd0, 16'sd0, 1, 1, 33'd65535, 13'd1));
      rows.push_back(mk(24'd1, 16'd5, 16'sd0, 16'sd0, 1, 1, 33'd0, 13'd0));
      rows.push_back(mkcfg(mk(24'hFFFFFF, 16'd0, -16'sd32768, -16'sd128, 1, 1,
                              33'd1073758208, 13'd1), 24'd0, 24'hFFFFFF,
                           sba_pkg::MODE_POWER));
      rows.push_back(mk(24'd0, 16'd0, 16'sd32767, 16'sd127, 1, 0, 33'd0, 13'd0));
      rows.push_back(mkcfg(mk(24'd9, 16'd0, 16'sd0, 16'sd0, 1, 1, 33'd0, 13'd1),
                           24'd0, 24'hFFFFFF, sba_pkg::MODE_PHASE));
      rows.push_back(mk(24'd9, 16'd0, 16'sd5, 16'sd0, 1, 1, 33'd0, 13'd1));
      rows.push_back(mk(24'd9, 16'd0, -16'sd5, 16'sd0, 1, 1, 33'd25736, 13'd1));
      rows.push_back(mk(24'd9, 16'd0, 16'sd0, 16'sd7, 1, 1, 33'd12868, 13'd1));
      rows.push_back(mk(24'd9, 16'd0, 16'sd0, -16'sd7, 1, 1, -33'sd12868, 13'd1));
      rows.push_back(mk(24'd9, 16'd0, 16'sd100, 16'sd100, 1, 0, 33'd0, 13'd0));
      rows.push_back(mk(24'd9, 16'd0, -16'sd100, -16'sd100, 1, 0, 33'd0, 13'd0));
      rows.push_back(mk(24'd9, 16'd0, -16'sd100, 16'sd100, 0, 0, 33'd0, 13'd0));
      rows.push_back(mk(24'd9, 16'd0, -16'sd32768, -16'sd1, 1, 0, 33'd0, 13'd0));
      rows.push_back(mkcfg(mk(24'd3, 16'd7, 16'sd0, 16'sd0, 1, 1, 33'd7, 13'd1),
                           24'd0, 24'd100, 2'd3));
      rows.push_back(mkcfg(mk(24'd7, 16'd9, 16'sd0, 16'sd0, 1, 1, 33'd0, 13'd0),
                           24'd10, 24'd5, sba_pkg::MODE_MAG));
      rows.push_back(mkcfg(mk(24'd5, 16'd3, 16'sd0, 16'sd0, 0, 0, 33'd0, 13'd0),
                           24'd5, 24'd5, sba_pkg::MODE_MAG));
      rows.push_back(mk(24'd5, 16'd4, 16'sd0, 16'sd0, 0, 0, 33'd0, 13'd0));
      rows.push_back(mk(24'd4, 16'd50, 16'sd0, 16'sd0, 0, 0, 33'd0, 13'd0));
      rows.push_back(mk(24'd6, 16'd50, 16'sd0, 16'sd0, 1, 1, 33'd3, 13'd2));

      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].cfg) settle_and_configure(rows[i].low, rows[i].high, rows[i].mode);
         r.avg = rows[i].avg; r.used = rows[i].used;
         send_bin(rows[i].freq, rows[i].value, rows[i].re, rows[i].im, rows[i].last,
                  rows[i].typed, r);
      end

      // mode changed inside the spectrum
      settle_and_configure(24'd0, 24'hFFFFFF, sba_pkg::MODE_MAG);
      calm = 1;
      for (int i = 0; i < 60; i++) begin
         if (i == 30) begin
            req_tvalid <= 0;
            repeat (20) @(posedge clock);
            write_reg(sba_pkg::REG_MODE, sba_pkg::MODE_POWER);
         end
         send_bin(24'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), i == 59, 0, r);
      end
      calm = 0;

      // receiver holds off while the bench keeps offering bins, each closing a spectrum
      settle_and_configure(24'd0, 24'hFFFFFF, sba_pkg::MODE_MAG);
      hold_now = 1;
      for (int i = 0; i < 40; i++)
         send_bin(24'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1, 0, r);
      hold_now = 0;

      for (int phase = 0; phase < 10; phase++) begin
         case (phase % 4)
            0: begin lo = 24'd0; hi = 24'hFFFFFF; end
            1: begin
               lo = 24'($urandom_range(0, 1000));
               hi = 24'(lo + $urandom_range(0, 1000));
            end
            2: begin lo = 24'($urandom); hi = 24'($urandom); end
            default: begin lo = 24'hFFFFFF; hi = 24'hFFFFFF; end
         endcase
         settle_and_configure(lo, hi, 2'($urandom_range(0, 3)));
         calm = (phase == 5);
         nframes = $urandom_range(8, 14);
         for (int f = 0; f < nframes; f++) begin
            len = $urandom_range(1, 10);
            for (int k = 0; k < len; k++)
               send_bin(($urandom_range(3) == 0) ? 24'($urandom)
                                                 : 24'(lo + $urandom_range(0, 2000)),
                        16'($urandom), 16'($urandom), 16'($urandom), k == len - 1, 0, r);
         end
      end
      calm = 0;

      req_tvalid <= 0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
